/* hdl/eva_pkg.sv */
package eva_pkg;

  // slot table
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // result bookkeeping per input beat
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // fixed point of the easing curve: 1024 steps
  localparam int FRAC_W    = 10;
  localparam int DIV_STEPS = FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ELAPSED_W = 17;

  typedef enum logic [1:0] {
    KIND_STARTED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_VALUE   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VAL,
    ST_ACK,
    ST_LOAD,
    ST_DIV,
    ST_EASE,
    ST_SCALE,
    ST_ADJ,
    ST_SVAL,
    ST_FIN,
    ST_FLUSH
  } state_e;

endpackage

/* hdl/eased_value_animator_top.sv */
// sequence: a start beat's first result passes the holding stage and output register; a tick beat takes
// a load step per free slot, and per running slot load, 10 divide, 3 scale and 2 report
// steps, per slot that finishes load and 2 report steps, plus a step to close the beat
// throughput: one beat at a time; the shared restoring divider makes one quotient bit
// per cycle, and report steps wait while the result side stalls
// reset: rst_ni clears the sequencer, busy flags and valids; slot data has no reset value
module eased_value_animator_top
  import eva_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         target_tag_i,
  input  logic signed [15:0] start_value_i,
  input  logic signed [15:0] end_value_i,
  input  logic [15:0]        length_ms_i,
  input  logic               want_step_i,
  input  logic               want_done_i,
  input  logic [15:0]        tick_ms_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [2:0]         slot_o,
  output logic [7:0]         tag_out_o,
  output logic signed [15:0] current_o,
  output logic               last_o
);

  // slot table, one read address (idx_q), small enough for flops
  logic [SLOT_COUNT-1:0]  busy_q;
  logic [7:0]             slot_tag_q    [SLOT_COUNT];
  logic signed [15:0]     slot_from_q   [SLOT_COUNT];
  logic signed [15:0]     slot_to_q     [SLOT_COUNT];
  logic [15:0]            slot_length_q [SLOT_COUNT];
  logic [ELAPSED_W-1:0]   slot_elapsed_q[SLOT_COUNT];
  logic [1:0]             slot_flags_q  [SLOT_COUNT];

  state_e state_q, state_d;

  logic [SLOT_W-1:0]    idx_q;
  logic [RES_CNT_W-1:0] res_cnt_q;

  // start beat context
  logic [7:0]         tag_q;
  logic signed [15:0] start_q;
  logic               full_q;

  // tick beat context
  logic [15:0]          tick_q;
  logic signed [15:0]   from_q;
  logic signed [15:0]   to_q;
  logic [15:0]          len_q;
  logic                 fin_q;
  logic [15:0]          rem_q;
  logic [FRAC_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [FRAC_W-1:0]    ease_q;
  logic signed [27:0]   prod_q;
  logic signed [15:0]   val_q;

  // one-deep holding stage: a result waits here until the next one or the end of
  // the beat tells whether it is the last
  logic               pend_v_q;
  kind_e              pend_kind_q;
  logic [2:0]         pend_slot_q;
  logic [7:0]         pend_tag_q;
  logic signed [15:0] pend_cur_q;

  // output register
  logic               out_v_q;
  kind_e              out_kind_q;
  logic [2:0]         out_slot_q;
  logic [7:0]         out_tag_q;
  logic signed [15:0] out_cur_q;
  logic               out_last_q;

  logic               acc;
  logic               out_free;
  logic               push_ok;
  logic               res_full;
  logic               emit_ok;
  logic               move;

  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               last_idx;
  logic [SLOT_W+2:0]  idx_ext;
  logic [2:0]         idx_slot;

  // combinational sequencer outputs
  logic               gen_want;
  logic               gen_v;
  kind_e              gen_kind;
  logic [2:0]         gen_slot;
  logic [7:0]         gen_tag;
  logic signed [15:0] gen_cur;
  logic               adv;
  logic               clr_busy;

  // datapath terms
  logic [ELAPSED_W:0]   el_sum;
  logic [ELAPSED_W-1:0] el_new;
  logic [16:0]          div_sh;
  logic                 div_ge;
  logic [11:0]          ease_cmp;
  logic [21:0]          ease_prod;
  logic signed [16:0]   delta;
  logic signed [10:0]   ease_s;
  logic signed [27:0]   prod_bias;
  logic signed [17:0]   quot;
  logic signed [17:0]   val_sum;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign out_free = !out_v_q || !out_stall_i;
  assign push_ok  = !pend_v_q || out_free;
  assign res_full = (res_cnt_q >= RES_CNT_W'(MAX_RESULTS));
  // a report beyond the per-beat limit is dropped, the walk still goes on
  assign emit_ok  = push_ok || res_full;
  assign gen_v    = gen_want && push_ok && !res_full;
  assign move     = pend_v_q && out_free && (gen_v || (state_q == ST_FLUSH));

  assign last_idx = (idx_q == SLOT_W'(SLOT_COUNT - 1));
  assign idx_ext  = {3'b000, idx_q};
  assign idx_slot = idx_ext[2:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // elapsed update and finish test
  assign el_sum = {1'b0, slot_elapsed_q[idx_q]} + {{(ELAPSED_W - 15){1'b0}}, tick_q};
  assign el_new = el_sum[ELAPSED_W-1:0];

  // restoring divide step: elapsed * 1024 / length, one quotient bit per cycle
  assign div_sh = {rem_q, 1'b0};
  assign div_ge = (div_sh >= {1'b0, len_q});

  // e = p * (2048 - p) / 1024
  assign ease_cmp  = 12'd2048 - {2'b00, quo_q};
  assign ease_prod = {12'd0, quo_q} * {10'd0, ease_cmp};

  // (to - from) * e, then divide by 1024 rounding toward zero
  assign delta     = {to_q[15], to_q} - {from_q[15], from_q};
  assign ease_s    = {1'b0, ease_q};
  assign prod_bias = prod_q + (prod_q[27] ? 28'sd1023 : 28'sd0);
  assign quot      = prod_bias[27:FRAC_W];
  assign val_sum   = {{2{from_q[15]}}, from_q} + quot;

  // sequencer: next state and report generation
  always_comb begin
    state_d  = state_q;
    gen_want = 1'b0;
    gen_kind = KIND_VALUE;
    gen_slot = idx_slot;
    gen_tag  = slot_tag_q[idx_q];
    gen_cur  = '0;
    adv      = 1'b0;
    clr_busy = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (func_i) begin
            state_d = ST_LOAD;
          end else if (free_found && want_step_i) begin
            state_d = ST_VAL;
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_VAL: begin
        gen_want = 1'b1;
        gen_kind = KIND_VALUE;
        gen_tag  = tag_q;
        gen_cur  = start_q;
        if (emit_ok) begin
          state_d = ST_ACK;
        end
      end
      ST_ACK: begin
        gen_want = 1'b1;
        gen_tag  = tag_q;
        if (full_q) begin
          gen_kind = KIND_FULL;
          gen_slot = 3'd0;
        end else begin
          gen_kind = KIND_STARTED;
        end
        if (emit_ok) begin
          state_d = ST_FLUSH;
        end
      end
      ST_LOAD: begin
        if (busy_q[idx_q]) begin
          if (el_new >= {1'b0, slot_length_q[idx_q]}) begin
            state_d = ST_SVAL;
          end else begin
            state_d = ST_DIV;
          end
        end else begin
          adv     = 1'b1;
          state_d = last_idx ? ST_FLUSH : ST_LOAD;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_EASE;
        end
      end
      ST_EASE: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = ST_ADJ;
      end
      ST_ADJ: begin
        state_d = ST_SVAL;
      end
      ST_SVAL: begin
        if (slot_flags_q[idx_q][0]) begin
          gen_want = 1'b1;
          gen_kind = KIND_VALUE;
          gen_cur  = val_q;
          if (emit_ok) begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        gen_kind = KIND_DONE;
        if (fin_q && slot_flags_q[idx_q][1]) begin
          gen_want = 1'b1;
        end
        if (!gen_want || emit_ok) begin
          clr_busy = fin_q;
          adv      = 1'b1;
          state_d  = last_idx ? ST_FLUSH : ST_LOAD;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      idx_q     <= '0;
      res_cnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (acc) begin
        res_cnt_q <= '0;
        idx_q     <= func_i ? '0 : free_idx;
        if (!func_i && free_found) begin
          busy_q[free_idx] <= 1'b1;
        end
      end else if (gen_v) begin
        res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
      end
      if (clr_busy) begin
        busy_q[idx_q] <= 1'b0;
      end
      if (adv && !last_idx) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (gen_v) begin
        pend_v_q <= 1'b1;
      end else if (move) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // slot table writes
  always_ff @(posedge clk_i) begin
    if (acc && !func_i && free_found) begin
      slot_tag_q[free_idx]     <= target_tag_i;
      slot_from_q[free_idx]    <= start_value_i;
      slot_to_q[free_idx]      <= end_value_i;
      slot_length_q[free_idx]  <= length_ms_i;
      slot_elapsed_q[free_idx] <= '0;
      slot_flags_q[free_idx]   <= {want_done_i, want_step_i};
    end
    if (state_q == ST_LOAD && busy_q[idx_q]) begin
      slot_elapsed_q[idx_q] <= el_new;
    end
  end

  // working registers of the shared datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tag_q   <= target_tag_i;
      start_q <= start_value_i;
      full_q  <= !free_found;
      tick_q  <= tick_ms_i;
    end
    case (state_q)
      ST_LOAD: begin
        from_q <= slot_from_q[idx_q];
        to_q   <= slot_to_q[idx_q];
        len_q  <= slot_length_q[idx_q];
        val_q  <= slot_to_q[idx_q];
        fin_q  <= (el_new >= {1'b0, slot_length_q[idx_q]});
        rem_q  <= el_new[15:0];
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= div_ge ? 16'(div_sh - {1'b0, len_q}) : div_sh[15:0];
        quo_q <= {quo_q[FRAC_W-2:0], div_ge};
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
      ST_EASE: begin
        ease_q <= ease_prod[2*FRAC_W-1:FRAC_W];
      end
      ST_SCALE: begin
        prod_q <= 28'(delta) * 28'(ease_s);
      end
      ST_ADJ: begin
        val_q <= val_sum[15:0];
      end
      default: begin
      end
    endcase
  end

  // holding stage and output register payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_tag_q  <= pend_tag_q;
      out_cur_q  <= pend_cur_q;
      out_last_q <= (state_q == ST_FLUSH);
    end
    if (gen_v) begin
      pend_kind_q <= gen_kind;
      pend_slot_q <= gen_slot;
      pend_tag_q  <= gen_tag;
      pend_cur_q  <= gen_cur;
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign slot_o      = out_slot_q;
  assign tag_out_o   = out_tag_q;
  assign current_o   = out_cur_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  // slot ownership only changes while a beat is being worked on
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !acc) |=> $stable(busy_q))
    else $error("busy flags changed while idle");

  // the holding stage is drained before a new beat is taken
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("result left in holding stage");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EASE |-> rem_q < len_q)
    else $error("divider remainder out of range");

  // report count never exceeds the per-beat limit
  a_res_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= RES_CNT_W'(MAX_RESULTS))
    else $error("too many reports");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
  import eva_pkg::*;
();

  // any stretch this long without an accepted beat on either side is a hang
  localparam int IDLE_LIMIT   = 2000;
  // drain margin after the last expected report, so a stray report has time to show up
  localparam int DRAIN_CYCLES = 200;

  typedef enum bit {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } anim_op_e;

  // one input beat, field for field
  typedef struct {
    anim_op_e           op;
    logic [7:0]         tag;
    logic signed [15:0] start_val;
    logic signed [15:0] end_val;
    logic [15:0]        length;
    logic               want_step;
    logic               want_done;
    logic [15:0]        tick;
  } anim_beat_t;

  // one result beat
  typedef struct {
    kind_e              kind;
    logic [2:0]         slot;
    logic [7:0]         tag;
    logic signed [15:0] current;
    logic               last;
  } anim_report_t;

  // slot table mirror: claims slots on starts, ages and eases them on ticks,
  // and queues the reports each beat must produce
  class animator_scoreboard;
    bit                 busy[SLOT_COUNT];
    logic [7:0]         tag[SLOT_COUNT];
    logic signed [15:0] start_val[SLOT_COUNT];
    logic signed [15:0] end_val[SLOT_COUNT];
    logic [15:0]        length[SLOT_COUNT];
    logic [16:0]        elapsed[SLOT_COUNT];
    logic               want_step[SLOT_COUNT];
    logic               want_done[SLOT_COUNT];
    anim_report_t       due_reports[$];
    anim_report_t       beat_reports[$];
    int                 mismatches;
    int                 checked;
    int                 kind_seen[4];
    int                 starts;
    int                 ticks;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      mismatches = 0;
      checked    = 0;
      starts     = 0;
      ticks      = 0;
    endfunction

    function void add_report(kind_e kind, int slot_idx, logic [7:0] tag_val,
                             logic signed [15:0] cur);
      anim_report_t r;
      if (beat_reports.size() >= MAX_RESULTS) return;
      r.kind    = kind;
      r.slot    = 3'(slot_idx);
      r.tag     = tag_val;
      r.current = cur;
      r.last    = 1'b0;
      beat_reports.push_back(r);
    endfunction

    // quadratic ease-out, division truncates toward zero
    function logic signed [15:0] eased_value(int s);
      int unsigned el;
      int unsigned len;
      int unsigned p;
      int unsigned e;
      int          delta;
      int          scaled;
      if (length[s] == 16'd0 || elapsed[s] >= length[s]) return end_val[s];
      el     = elapsed[s];
      len    = length[s];
      p      = (el * 1024) / len;
      e      = (p * (2048 - p)) / 1024;
      delta  = int'(end_val[s]) - int'(start_val[s]);
      scaled = (delta * int'(e)) / 1024;
      return 16'(int'(start_val[s]) + scaled);
    endfunction

    function void note_beat(anim_beat_t b);
      int claimed;
      beat_reports.delete();
      if (b.op == OP_START) begin
        starts++;
        claimed = -1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (!busy[s] && claimed < 0) claimed = s;
        end
        if (claimed < 0) begin
          add_report(KIND_FULL, 0, b.tag, '0);
        end else begin
          busy[claimed]      = 1'b1;
          tag[claimed]       = b.tag;
          start_val[claimed] = b.start_val;
          end_val[claimed]   = b.end_val;
          length[claimed]    = b.length;
          elapsed[claimed]   = '0;
          want_step[claimed] = b.want_step;
          want_done[claimed] = b.want_done;
          if (b.want_step) add_report(KIND_VALUE, claimed, b.tag, b.start_val);
          add_report(KIND_STARTED, claimed, b.tag, '0);
        end
      end else begin
        ticks++;
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (busy[s]) begin
            elapsed[s] = elapsed[s] + 17'(b.tick);
            if (want_step[s]) add_report(KIND_VALUE, s, tag[s], eased_value(s));
            if (elapsed[s] >= length[s]) begin
              busy[s] = 1'b0;
              if (want_done[s]) add_report(KIND_DONE, s, tag[s], '0);
            end
          end
        end
      end
      if (beat_reports.size() > 0) beat_reports[beat_reports.size() - 1].last = 1'b1;
      foreach (beat_reports[i]) due_reports.push_back(beat_reports[i]);
    endfunction

    function void check_report(anim_report_t got);
      anim_report_t want;
      if (due_reports.size() == 0) begin
        $error("unexpected report: kind %0d slot %0d tag %0d current %0d",
               got.kind, got.slot, got.tag, got.current);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      checked++;
      kind_seen[int'(got.kind)]++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.tag !== want.tag) begin
        $error("tag_out: expected %0d, got %0d", want.tag, got.tag);
        mismatches++;
      end
      if (got.current !== want.current) begin
        $error("current: expected %0d, got %0d", want.current, got.current);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               func_i        = 1'b0;
  logic [7:0]         target_tag_i  = '0;
  logic signed [15:0] start_value_i = '0;
  logic signed [15:0] end_value_i   = '0;
  logic [15:0]        length_ms_i   = '0;
  logic               want_step_i   = 1'b0;
  logic               want_done_i   = 1'b0;
  logic [15:0]        tick_ms_i     = '0;
  logic               out_stall_i   = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         kind_o;
  logic [2:0]         slot_o;
  logic [7:0]         tag_out_o;
  logic signed [15:0] current_o;
  logic               last_o;

  // idle odds in percent, switched per phase
  int                 send_idle_pct;
  int                 recv_stall_pct;
  animator_scoreboard board;

  always #2 clk_i = ~clk_i;

  eased_value_animator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .target_tag_i  (target_tag_i),
    .start_value_i (start_value_i),
    .end_value_i   (end_value_i),
    .length_ms_i   (length_ms_i),
    .want_step_i   (want_step_i),
    .want_done_i   (want_done_i),
    .tick_ms_i     (tick_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .slot_o        (slot_o),
    .tag_out_o     (tag_out_o),
    .current_o     (current_o),
    .last_o        (last_o)
  );

  // beat builders; fields the operation ignores carry random noise
  function automatic anim_beat_t make_start(logic [7:0] tag, logic [15:0] sv,
                                            logic [15:0] ev, logic [15:0] len,
                                            logic step, logic done);
    anim_beat_t b;
    b.op        = OP_START;
    b.tag       = tag;
    b.start_val = sv;
    b.end_val   = ev;
    b.length    = len;
    b.want_step = step;
    b.want_done = done;
    b.tick      = 16'($urandom);
    return b;
  endfunction

  function automatic anim_beat_t make_tick(logic [15:0] ms);
    anim_beat_t b;
    b = make_start(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 1'($urandom));
    b.op   = OP_TICK;
    b.tick = ms;
    return b;
  endfunction

  // endpoints lean on the extremes now and then
  function automatic logic [15:0] random_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short animations so slots keep turning over
  function automatic anim_beat_t random_start();
    logic [15:0] len;
    case ($urandom_range(15))
      0:       len = 16'd0;
      1:       len = 16'($urandom);
      default: len = 16'($urandom_range(1, 300));
    endcase
    return make_start(8'($urandom), random_value(), random_value(), len,
                      1'($urandom), 1'($urandom));
  endfunction

  function automatic anim_beat_t random_tick();
    case ($urandom_range(15))
      0:       return make_tick(16'd0);
      1:       return make_tick(16'hffff);
      2:       return make_tick(16'($urandom));
      default: return make_tick(16'($urandom_range(1, 60)));
    endcase
  endfunction

  // offer one beat, hold it steady until the block takes it
  task automatic send_beat(anim_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= b.op;
    target_tag_i  <= b.tag;
    start_value_i <= b.start_val;
    end_value_i   <= b.end_val;
    length_ms_i   <= b.length;
    want_step_i   <= b.want_step;
    want_done_i   <= b.want_done;
    tick_ms_i     <= b.tick;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    board.note_beat(b);
  endtask

  // starts and ticks mixed, with bursts of starts that run the table full
  task automatic random_phase(int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(4, 9)) begin
          send_beat(random_start());
          sent++;
        end
      end else if ($urandom_range(99) < 40) begin
        send_beat(random_start());
        sent++;
      end else begin
        send_beat(random_tick());
        sent++;
      end
    end
  endtask

  // result side: check every accepted report, then pick next cycle's stall
  always @(posedge clk_i) begin
    anim_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind    = kind_e'(kind_o);
      got.slot    = slot_o;
      got.tag     = tag_out_o;
      got.current = current_o;
      got.last    = last_o;
      board.check_report(got);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // hang detector: counts cycles in which neither channel moves a beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $error("no beat accepted for %0d cycles, %0d reports outstanding",
           IDLE_LIMIT, board.due_reports.size());
    $display("eased_value_animator_top regression: fail");
    $finish;
  end

  initial begin
    board          = new();
    send_idle_pct  = 16;
    recv_stall_pct = 59;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table gives nothing back
    send_beat(make_tick(16'd7));
    // full-swing ramps both ways, a zero-length one and a silent one
    send_beat(make_start(8'h00, 16'h8000, 16'h7fff, 16'd1000, 1'b1, 1'b1));
    send_beat(make_start(8'hff, 16'h7fff, 16'h8000, 16'hffff, 1'b1, 1'b0));
    send_beat(make_start(8'h5a, 16'd0, 16'd100, 16'd0, 1'b0, 1'b1));
    send_beat(make_start(8'ha5, 16'd100, -16'sd100, 16'd1, 1'b0, 1'b0));
    // zero tick finishes the zero-length slot only
    send_beat(make_tick(16'd0));
    send_beat(make_tick(16'd500));
    // largest tick runs past the end of the longest animation
    send_beat(make_tick(16'hffff));

    // fill every slot, overflow once, then finish all at once for sixteen reports
    repeat (SLOT_COUNT) begin
      send_beat(make_start(8'($urandom), random_value(), random_value(),
                           16'($urandom_range(1, 5000)), 1'b1, 1'b1));
    end
    send_beat(make_start(8'hc3, 16'h1234, 16'hedcb, 16'd40, 1'b1, 1'b1));
    send_beat(make_tick(16'hffff));

    random_phase(107);
    send_idle_pct  = 59;
    recv_stall_pct = 16;
    random_phase(107);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(106);
    in_valid_i <= 1'b0;

    // drain, then give a stray report time to show up
    while (board.due_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d starts and %0d ticks across three idle/stall mixes",
             board.starts, board.ticks);
    $display("checked %0d reports: %0d started, %0d full, %0d value, %0d done",
             board.checked, board.kind_seen[KIND_STARTED], board.kind_seen[KIND_FULL],
             board.kind_seen[KIND_VALUE], board.kind_seen[KIND_DONE]);
    if (board.mismatches == 0 && board.due_reports.size() == 0) begin
      $display("eased_value_animator_top regression: pass");
    end else begin
      $display("eased_value_animator_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/eva_pkg.sv
hdl/eased_value_animator_top.sv
test/tb_top.sv
